// ===== rtl/screen_marker_radius_clustering_assert.svh =====
// Assertion macros used by the checker file of the marker clustering block
`ifndef SCREEN_MARKER_RADIUS_CLUSTERING_ASSERT_SVH
`define SCREEN_MARKER_RADIUS_CLUSTERING_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define SMRC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define SMRC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/smrc_pkg.sv =====
// Types, sizes and controller states of the marker clustering block
package smrc_pkg;

    localparam int MAX_MARKERS = 64;
    localparam int COORD_BITS  = 16;

    localparam int IDX_BITS  = $clog2(MAX_MARKERS);
    localparam int CNT_BITS  = $clog2(MAX_MARKERS + 1);
    localparam int RAD_BITS  = 12;
    localparam int RSC_BITS  = RAD_BITS + 4;
    localparam int MAG_BITS  = (COORD_BITS > RSC_BITS) ? COORD_BITS : RSC_BITS;
    localparam int SQ_BITS   = 2 * MAG_BITS + 1;
    localparam int VCNT_BITS = 7;

    localparam logic [CNT_BITS-1:0]  MAX_CNT  = CNT_BITS'(MAX_MARKERS);
    localparam logic [VCNT_BITS-1:0] VCNT_MAX = '1;

    typedef struct packed {
        logic [15:0]                   marker_tag;
        logic signed [COORD_BITS-1:0]  screen_x;
        logic signed [COORD_BITS-1:0]  screen_y;
        logic                          on_screen;
        logic signed [11:0]            arrow_angle;
        logic [7:0]                    opacity;
        logic [23:0]                   distance;
        logic                          last_marker;
    } marker_in_t;

    typedef struct packed {
        logic [15:0]                   tag;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic                          on;
        logic signed [11:0]            angle;
        logic [7:0]                    opacity;
        logic [23:0]                   distance;
    } entry_t;

    typedef struct packed {
        logic [15:0]                   view_tag;
        logic signed [COORD_BITS-1:0]  view_x;
        logic signed [COORD_BITS-1:0]  view_y;
        logic                          view_on_screen;
        logic signed [11:0]            view_angle;
        logic [7:0]                    view_opacity;
        logic [23:0]                   view_distance;
        logic [VCNT_BITS-1:0]          cluster_count;
        logic                          last_view;
    } view_t;

    typedef struct packed {
        logic store_wr;
        logic head_issue;
        logic head_skip;
        logic head_latch;
        logic scan_issue;
        logic finish;
        logic last_push;
    } dp_cmd_t;

    typedef struct packed {
        logic head_done;
        logic head_absorbed;
        logic head_clusters;
        logic scan_done;
        logic pipe_busy;
        logic pend_free;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_HEAD,
        ST_HLATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_LAST
    } state_t;

endpackage

// ===== rtl/screen_marker_radius_clustering.sv =====
// Top level of the screen marker radius clustering block
//
//  channel | ports                        | word
//  --------+------------------------------+---------------------------------
//  input   | s_valid s_ready s_data       | one marker, last_marker ends set
//  result  | m_valid m_ready m_data       | one view per cluster head
//  config  | cfg_valid cfg_ready cfg_data | cluster radius in whole pixels
//
// Markers load at one per cycle until the last marker, on which the set is
// clustered through the single read port of the store: an absorbed index
// is skipped, a head is read and latched, and a head that clusters then has
// every later stored marker read and tested through the distance pipeline.
// Reset is synchronous and needs no clearing pass. A stalled result holds
// the pass; the final view may wait while the next set loads.
module screen_marker_radius_clustering import smrc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  marker_in_t          s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output view_t               m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RAD_BITS-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Take register writes at any time
    assign cfg_ready = 1'b1;

    smrc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_marker),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    smrc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule

// ===== rtl/smrc_ctrl.sv =====
// Sequencer for loading a marker set and walking heads and candidates
module smrc_ctrl import smrc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_last,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decide next state and issue commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.store_wr = 1'b1;
                    if (s_last) begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                if (stat.head_done) begin
                    state_next = ST_LAST;
                end else if (stat.head_absorbed) begin
                    cmd.head_skip = 1'b1;
                end else begin
                    cmd.head_issue = 1'b1;
                    state_next     = ST_HLATCH;
                end
            end
            ST_HLATCH: begin
                cmd.head_latch = 1'b1;
                state_next     = stat.head_clusters ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.scan_issue = 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.pend_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_LAST: begin
                if (stat.out_free) begin
                    cmd.last_push = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/smrc_datapath.sv =====
// Marker store, absorbed map, distance pipeline and view registers
module smrc_datapath import smrc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [RAD_BITS-1:0] cfg_data,
    input  marker_in_t          s_data,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    output view_t               m_data,
    output logic                m_valid,
    input  logic                m_ready
);

    entry_t                   mem [MAX_MARKERS];
    entry_t                   rd_reg;
    logic [IDX_BITS-1:0]      rd_addr;

    logic [CNT_BITS-1:0]      count_reg;
    logic [CNT_BITS-1:0]      head_reg;
    logic [CNT_BITS-1:0]      scan_reg;
    logic [MAX_MARKERS-1:0]   absorbed_reg;

    logic [RAD_BITS-1:0]      radius_reg;
    logic [2*RSC_BITS-1:0]    rsq_reg;
    logic [MAG_BITS-1:0]      rsc;

    entry_t                   hd_reg;
    logic [7:0]               opac_reg;
    logic [23:0]              dist_reg;
    logic [VCNT_BITS-1:0]     cnt_reg;

    // candidate pipeline
    logic                     p1_valid_reg;
    logic [IDX_BITS-1:0]      p1_idx_reg;
    logic                     p2_valid_reg, p3_valid_reg;
    logic [IDX_BITS-1:0]      p2_idx_reg, p3_idx_reg;
    logic                     p2_match_reg, p3_match_reg;
    logic [MAG_BITS-1:0]      p2_dx_reg, p2_dy_reg;
    logic [2*MAG_BITS-1:0]    p3_dx2_reg, p3_dy2_reg;
    logic [23:0]              p2_dist_reg, p3_dist_reg;
    logic [7:0]               p2_opac_reg, p3_opac_reg;

    logic signed [COORD_BITS:0] ddx, ddy, adx, ady;
    logic [MAG_BITS-1:0]      dx, dy;
    logic                     match;
    logic [SQ_BITS-1:0]       sq_sum;
    logic                     hit;

    view_t                    pend_reg, out_reg, new_view, pend_last;
    logic                     pend_valid_reg, out_valid_reg;
    logic                     out_free;

    // Hold the radius and its scaled square
    assign rsc = MAG_BITS'({radius_reg, 4'b0000});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
        end else if (cfg_valid) begin
            radius_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        rsq_reg <= (2*RSC_BITS)'(rsc) * (2*RSC_BITS)'(rsc);
    end

    // Write the store at the fill count, read at head or scan index
    assign rd_addr = cmd.head_issue ? head_reg[IDX_BITS-1:0] : scan_reg[IDX_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.store_wr && count_reg != MAX_CNT) begin
            mem[count_reg[IDX_BITS-1:0]] <= '{tag:      s_data.marker_tag,
                                              x:        s_data.screen_x,
                                              y:        s_data.screen_y,
                                              on:       s_data.on_screen,
                                              angle:    s_data.arrow_angle,
                                              opacity:  s_data.opacity,
                                              distance: s_data.distance};
        end
        rd_reg <= mem[rd_addr];
    end

    // Coarse test: tag, on-screen flag and box around the head
    always_comb begin
        ddx   = {rd_reg.x[COORD_BITS-1], rd_reg.x} - {hd_reg.x[COORD_BITS-1], hd_reg.x};
        ddy   = {rd_reg.y[COORD_BITS-1], rd_reg.y} - {hd_reg.y[COORD_BITS-1], hd_reg.y};
        adx   = ddx[COORD_BITS] ? -ddx : ddx;
        ady   = ddy[COORD_BITS] ? -ddy : ddy;
        dx    = MAG_BITS'(adx[COORD_BITS-1:0]);
        dy    = MAG_BITS'(ady[COORD_BITS-1:0]);
        match = rd_reg.on && (rd_reg.tag == hd_reg.tag) && (dx <= rsc) && (dy <= rsc);
    end

    // Advance the candidate pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= cmd.scan_issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_idx_reg   <= scan_reg[IDX_BITS-1:0];
        p2_idx_reg   <= p1_idx_reg;
        p2_match_reg <= match;
        p2_dx_reg    <= dx;
        p2_dy_reg    <= dy;
        p2_dist_reg  <= rd_reg.distance;
        p2_opac_reg  <= rd_reg.opacity;
        p3_idx_reg   <= p2_idx_reg;
        p3_match_reg <= p2_match_reg;
        p3_dx2_reg   <= (2*MAG_BITS)'(p2_dx_reg) * (2*MAG_BITS)'(p2_dx_reg);
        p3_dy2_reg   <= (2*MAG_BITS)'(p2_dy_reg) * (2*MAG_BITS)'(p2_dy_reg);
        p3_dist_reg  <= p2_dist_reg;
        p3_opac_reg  <= p2_opac_reg;
    end

    // Fine test on the squared distance
    assign sq_sum = SQ_BITS'(p3_dx2_reg) + SQ_BITS'(p3_dy2_reg);
    assign hit    = p3_valid_reg && p3_match_reg && !absorbed_reg[p3_idx_reg] &&
                    (sq_sum <= SQ_BITS'(rsq_reg));

    // Track fill count, head and scan indexes, absorbed map
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            head_reg     <= '0;
            scan_reg     <= '0;
            absorbed_reg <= '0;
        end else begin
            if (cmd.store_wr && count_reg != MAX_CNT) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.head_skip || cmd.finish) begin
                head_reg <= head_reg + 1'b1;
            end
            if (cmd.head_latch) begin
                scan_reg <= head_reg + 1'b1;
            end else if (cmd.scan_issue) begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (hit) begin
                absorbed_reg[p3_idx_reg] <= 1'b1;
            end
            if (cmd.last_push) begin
                count_reg    <= '0;
                head_reg     <= '0;
                absorbed_reg <= '0;
            end
        end
    end

    // Latch the head and fold in absorbed members
    always_ff @(posedge aclk) begin
        if (cmd.head_latch) begin
            hd_reg   <= rd_reg;
            opac_reg <= rd_reg.opacity;
            dist_reg <= rd_reg.distance;
            cnt_reg  <= VCNT_BITS'(1);
        end else if (hit) begin
            if (cnt_reg != VCNT_MAX) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (p3_dist_reg < dist_reg) begin
                dist_reg <= p3_dist_reg;
                if (p3_opac_reg > opac_reg) begin
                    opac_reg <= p3_opac_reg;
                end
            end
        end
    end

    // Hold one view back so the final one of the set can be flagged
    assign new_view = '{view_tag:       hd_reg.tag,
                        view_x:         hd_reg.x,
                        view_y:         hd_reg.y,
                        view_on_screen: hd_reg.on,
                        view_angle:     hd_reg.angle,
                        view_opacity:   opac_reg,
                        view_distance:  dist_reg,
                        cluster_count:  cnt_reg,
                        last_view:      1'b0};

    // Flag the held view as the final one of the set
    always_comb begin
        pend_last           = pend_reg;
        pend_last.last_view = 1'b1;
    end

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.finish) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.last_push) begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.finish && pend_valid_reg) || cmd.last_push) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            pend_reg <= new_view;
            if (pend_valid_reg) begin
                out_reg <= pend_reg;
            end
        end else if (cmd.last_push) begin
            out_reg <= pend_last;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

    // Report status to the sequencer
    always_comb begin
        stat               = '0;
        stat.head_done     = (head_reg == count_reg);
        stat.head_absorbed = absorbed_reg[head_reg[IDX_BITS-1:0]];
        stat.head_clusters = rd_reg.on && (radius_reg != '0);
        stat.scan_done     = (scan_reg == count_reg);
        stat.pipe_busy     = p1_valid_reg || p2_valid_reg || p3_valid_reg;
        stat.pend_free     = !pend_valid_reg || out_free;
        stat.out_free      = out_free;
    end

endmodule

// ===== rtl/smrc_checker.sv =====
// Port-level checks of the marker clustering block and their binding
`include "screen_marker_radius_clustering_assert.svh"

module smrc_checker import smrc_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input marker_in_t          s_data,
    input logic                m_valid,
    input logic                m_ready,
    input view_t               m_data,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [RAD_BITS-1:0] cfg_data
);

    // a stalled view holds its word
    `SMRC_ASSERT_NXT(a_view_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "view changed while stalled")

    // the last marker stops loading while the set is clustered
    `SMRC_ASSERT_NXT(a_last_stops, aclk, aresetn, s_valid && s_ready && s_data.last_marker, !s_ready, "input still taken after last marker")

    // loading continues until the last marker
    `SMRC_ASSERT_NXT(a_load_runs, aclk, aresetn, s_valid && s_ready && !s_data.last_marker, s_ready, "loading stopped before last marker")

    // every view counts at least its head
    `SMRC_ASSERT_IMP(a_count_nonzero, aclk, aresetn, m_valid, m_data.cluster_count != '0, "view with zero count")

endmodule

bind screen_marker_radius_clustering smrc_checker u_smrc_checker (.*);

// ===== test/tb_screen_marker_radius_clustering.sv =====
// Testbench for the screen marker radius clustering block: directed and random sets, self-checking
`timescale 1ns / 1ps

module tb_screen_marker_radius_clustering;
    import smrc_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 40;
    localparam int ITEM_GOAL    = 420;
    localparam int COORD_MIN    = -(1 <<< (COORD_BITS - 1));
    localparam int COORD_MAX    = (1 <<< (COORD_BITS - 1)) - 1;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    marker_in_t          s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    view_t               m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [RAD_BITS-1:0] cfg_data = '0;

    screen_marker_radius_clustering dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Local copy of the block state
    entry_t              marker_mem [MAX_MARKERS];
    bit                  absorbed   [MAX_MARKERS];
    int                  stored_count = 0;
    logic [RAD_BITS-1:0] radius_px = '0;

    marker_in_t markers_to_send [$];
    view_t      views_due [$];
    int         markers_queued = 0;
    int         markers_taken  = 0;
    int         fault_count    = 0;
    int         quiet_cycles   = 0;

    int tx_gap = 0, tx_calm = 0;
    int rx_stall = 0, rx_calm = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 6);
    endfunction

    function automatic bit within_radius(entry_t a, entry_t b);
        longint r, dx, dy;
        r  = longint'(radius_px) * 16;
        dx = longint'(a.x) - longint'(b.x);
        dy = longint'(a.y) - longint'(b.y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx > r || dy > r) return 1'b0;
        return (dx * dx + dy * dy) <= r * r;
    endfunction

    // Store one marker; on the last of a set, cluster greedily and queue the views
    task automatic take_marker(input marker_in_t mk);
        entry_t      h, m;
        view_t       v;
        view_t       set_views [$];
        int          cnt;
        logic [7:0]  opac;
        logic [23:0] near_dist;
        if (stored_count < MAX_MARKERS) begin
            m.tag      = mk.marker_tag;
            m.x        = mk.screen_x;
            m.y        = mk.screen_y;
            m.on       = mk.on_screen;
            m.angle    = mk.arrow_angle;
            m.opacity  = mk.opacity;
            m.distance = mk.distance;
            marker_mem[stored_count] = m;
            stored_count++;
        end
        if (!mk.last_marker) return;
        for (int i = 0; i < stored_count; i++) begin
            if (absorbed[i]) continue;
            h         = marker_mem[i];
            opac      = h.opacity;
            near_dist = h.distance;
            cnt       = 1;
            if (h.on && radius_px != 0) begin
                for (int j = i + 1; j < stored_count; j++) begin
                    m = marker_mem[j];
                    if (absorbed[j] || !m.on || m.tag != h.tag) continue;
                    if (within_radius(m, h)) begin
                        absorbed[j] = 1'b1;
                        if (cnt < int'(VCNT_MAX)) cnt++;
                        if (m.distance < near_dist) begin
                            near_dist = m.distance;
                            if (m.opacity > opac) opac = m.opacity;
                        end
                    end
                end
            end
            v.view_tag       = h.tag;
            v.view_x         = h.x;
            v.view_y         = h.y;
            v.view_on_screen = h.on;
            v.view_angle     = h.angle;
            v.view_opacity   = opac;
            v.view_distance  = near_dist;
            v.cluster_count  = VCNT_BITS'(cnt);
            v.last_view      = 1'b0;
            set_views.push_back(v);
        end
        if (set_views.size() > 0) set_views[set_views.size() - 1].last_view = 1'b1;
        foreach (set_views[k]) views_due.push_back(set_views[k]);
        foreach (absorbed[k]) absorbed[k] = 1'b0;
        stored_count = 0;
    endtask

    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) note_fault($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    endtask

    // Compare a view word with the oldest expectation
    task automatic check_view(input view_t got);
        view_t want;
        if (views_due.size() == 0) begin
            note_fault($sformatf("unexpected view word 0x%0h", got));
            return;
        end
        want = views_due.pop_front();
        check_field("view_tag",       want.view_tag,       got.view_tag);
        check_field("view_x",         want.view_x,         got.view_x);
        check_field("view_y",         want.view_y,         got.view_y);
        check_field("view_on_screen", want.view_on_screen, got.view_on_screen);
        check_field("view_angle",     want.view_angle,     got.view_angle);
        check_field("view_opacity",   want.view_opacity,   got.view_opacity);
        check_field("view_distance",  want.view_distance,  got.view_distance);
        check_field("cluster_count",  want.cluster_count,  got.cluster_count);
        check_field("last_view",      want.last_view,      got.last_view);
    endtask

    // Driver: present queued markers, with gaps between words
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                take_marker(s_data);
                markers_taken++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (markers_to_send.size() > 0) begin
                    s_data  <= markers_to_send.pop_front();
                    s_valid <= 1'b1;
                    if (tx_calm > 0) begin
                        tx_calm--;
                    end else begin
                        tx_gap = idle_len();
                        if ($urandom_range(31) == 0) tx_calm = $urandom_range(60, 20);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take view words, stalling at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_view(m_data);
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (rx_calm > 0) rx_calm--;
                else if ($urandom_range(7) == 0) rx_stall = idle_len();
                else if ($urandom_range(63) == 0) rx_calm = $urandom_range(80, 20);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [COORD_BITS-1:0] to_coord(input int v);
        if (v < COORD_MIN) v = COORD_MIN;
        if (v > COORD_MAX) v = COORD_MAX;
        return COORD_BITS'(v);
    endfunction

    task automatic queue_marker(input int tag, input int x, input int y, input bit on,
                                input int ang, input int op, input int range_v, input bit last);
        marker_in_t mk;
        mk.marker_tag  = 16'(tag);
        mk.screen_x    = to_coord(x);
        mk.screen_y    = to_coord(y);
        mk.on_screen   = on;
        mk.arrow_angle = 12'(ang);
        mk.opacity     = 8'(op);
        mk.distance    = 24'(range_v);
        mk.last_marker = last;
        markers_to_send.push_back(mk);
        markers_queued++;
    endtask

    // One random set: mostly markers grouped round a few centres with shared tags
    task automatic queue_random_set(input int n);
        logic [15:0] tags [3];
        int          cx [3], cy [3];
        int          spread, c;
        marker_in_t  mk;
        spread = (radius_px == 0) ? 64 : int'(radius_px) * 24;
        if (spread > 30000) spread = 30000;
        for (int k = 0; k < 3; k++) begin
            tags[k] = 16'($urandom);
            cx[k]   = int'($urandom_range(65535)) - 32768;
            cy[k]   = int'($urandom_range(65535)) - 32768;
        end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 85) begin
                c = $urandom_range(2);
                mk.marker_tag = ($urandom_range(4) == 0) ? tags[$urandom_range(2)] : tags[c];
                mk.screen_x   = to_coord(cx[c] + int'($urandom_range(2 * spread)) - spread);
                mk.screen_y   = to_coord(cy[c] + int'($urandom_range(2 * spread)) - spread);
                mk.on_screen  = ($urandom_range(9) != 0);
            end else begin
                mk.marker_tag = 16'($urandom);
                mk.screen_x   = COORD_BITS'($urandom);
                mk.screen_y   = COORD_BITS'($urandom);
                mk.on_screen  = 1'($urandom);
            end
            mk.arrow_angle = 12'(int'($urandom_range(3600)) - 1800);
            mk.opacity     = 8'($urandom);
            mk.distance    = 24'($urandom);
            mk.last_marker = (k == n - 1);
            markers_to_send.push_back(mk);
            markers_queued++;
        end
    endtask

    task automatic wait_idle();
        while (markers_taken != markers_queued || views_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [RAD_BITS-1:0] r);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do @(posedge aclk); while (!cfg_ready);
        radius_px = r;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int phase_no, sets, p, n;
        logic [RAD_BITS-1:0] r;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Radius left at reset (zero): coincident markers stay apart, field extremes
        queue_marker(16'h0000, COORD_MIN, COORD_MAX, 1'b1, -1800, 0, 0, 1'b0);
        queue_marker(16'h0000, COORD_MIN, COORD_MAX, 1'b1, 1800, 255, 24'hFFFFFF, 1'b1);
        // Single-marker set, off screen
        queue_marker(16'hFFFF, COORD_MAX, COORD_MIN, 1'b0, 0, 255, 24'hFFFFFF, 1'b1);
        wait_idle();
        repeat (SETTLE_TICKS) @(posedge aclk);

        // One pixel: boundary, tag, on-screen and nearest-member cases
        write_radius(12'd1);
        queue_marker(5, 0, 0, 1'b1, 100, 100, 1000, 1'b0);
        queue_marker(5, 16, 0, 1'b1, 0, 50, 2000, 1'b0);
        queue_marker(5, 17, 0, 1'b1, 0, 90, 3000, 1'b0);
        queue_marker(5, 11, 12, 1'b1, 0, 70, 900, 1'b0);
        queue_marker(6, 0, 0, 1'b1, 0, 30, 10, 1'b0);
        queue_marker(5, 0, 0, 1'b0, 0, 30, 10, 1'b0);
        queue_marker(5, 0, 5, 1'b1, 0, 200, 500, 1'b0);
        queue_marker(5, 5, 0, 1'b1, 0, 10, 400, 1'b0);
        queue_marker(5, -16, 0, 1'b1, 0, 255, 400, 1'b1);
        wait_idle();
        repeat (SETTLE_TICKS) @(posedge aclk);

        // Widest radius: corner to corner, exact edge, centre
        write_radius(12'd4095);
        queue_marker(7, COORD_MIN, COORD_MIN, 1'b1, 10, 1, 50, 1'b0);
        queue_marker(7, COORD_MAX, COORD_MAX, 1'b1, 20, 2, 40, 1'b0);
        queue_marker(7, COORD_MAX - 15, COORD_MIN, 1'b1, 30, 3, 30, 1'b0);
        queue_marker(7, 0, 0, 1'b1, 40, 4, 60, 1'b1);
        // Off-screen head does not absorb its on-screen twin
        queue_marker(8, 0, 0, 1'b0, 0, 9, 9, 1'b0);
        queue_marker(8, 0, 0, 1'b1, 0, 9, 9, 1'b1);
        wait_idle();
        repeat (SETTLE_TICKS) @(posedge aclk);

        // Random phases, one radius each
        phase_no = 0;
        while (markers_queued < ITEM_GOAL) begin
            case (phase_no % 5)
                0:       r = 12'd4095;
                1:       r = RAD_BITS'($urandom_range(8, 1));
                2:       r = '0;
                3:       r = RAD_BITS'($urandom_range(200, 9));
                default: r = RAD_BITS'($urandom_range(4095, 1));
            endcase
            write_radius(r);
            // Overfill the store once, fill it exactly once
            if (phase_no == 0) queue_random_set(66);
            if (phase_no == 1) queue_random_set(MAX_MARKERS);
            sets = $urandom_range(6, 3);
            for (int s = 0; s < sets && markers_queued < ITEM_GOAL; s++) begin
                p = $urandom_range(99);
                if (p < 80) n = $urandom_range(10, 1);
                else if (p < 95) n = $urandom_range(32, 11);
                else n = $urandom_range(70, 60);
                queue_random_set(n);
            end
            wait_idle();
            repeat (SETTLE_TICKS) @(posedge aclk);
            phase_no++;
        end

        if (fault_count == 0 && views_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/smrc_pkg.sv
rtl/smrc_ctrl.sv
rtl/smrc_datapath.sv
rtl/screen_marker_radius_clustering.sv
rtl/smrc_checker.sv
test/tb_screen_marker_radius_clustering.sv
